FILE: rtl/bcm_pkg.sv
// bcm_pkg: shared constants, payload types and control structs for the
// binary classifier metrics block. No dependencies.
`default_nettype none
package bcm_pkg;

   // Widths
   localparam int INPUT_BITS  = 16;
   localparam int COUNT_BITS  = 16;
   localparam int FRAC_BITS   = 16;
   localparam int FRAC_W      = FRAC_BITS + 1;          // ratio field, 1.0 fits
   localparam int DEN_W       = COUNT_BITS + 2;         // sum of four counters
   localparam int ITER_BITS   = $clog2(FRAC_W + 1);
   localparam int NUM_RATIOS  = 4;
   localparam int SEL_BITS    = $clog2(NUM_RATIOS);

   // Ratio codes, also the undefined_mask bit positions
   localparam logic [SEL_BITS-1:0] RATIO_ACC  = SEL_BITS'(0);
   localparam logic [SEL_BITS-1:0] RATIO_PREC = SEL_BITS'(1);
   localparam logic [SEL_BITS-1:0] RATIO_REC  = SEL_BITS'(2);
   localparam logic [SEL_BITS-1:0] RATIO_FMEAS = SEL_BITS'(3);

   typedef struct packed {
      logic signed [INPUT_BITS-1:0] predicted_score;
      logic signed [INPUT_BITS-1:0] actual_label;
      logic                         last_pair;
   } req_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] true_pos_count;
      logic [COUNT_BITS-1:0] true_neg_count;
      logic [COUNT_BITS-1:0] false_pos_count;
      logic [COUNT_BITS-1:0] false_neg_count;
      logic [FRAC_W-1:0]     accuracy_frac;
      logic [FRAC_W-1:0]     precision_frac;
      logic [FRAC_W-1:0]     recall_frac;
      logic [FRAC_W-1:0]     fmeasure_frac;
      logic [NUM_RATIOS-1:0] undefined_mask;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic                count_en;   // request accepted, classify it
      logic                div_start;  // load divider for ratio sel
      logic                store;      // quotient ready, write ratio sel
      logic                push;       // load output register, clear counters
      logic [SEL_BITS-1:0] sel;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic div_done;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

FILE: rtl/bcm_div.sv
// bcm_div: restoring divider, one quotient bit per cycle.
// Computes floor(num * 2^FRAC_BITS / den) for num <= den. Uses bcm_pkg.
`default_nettype none
module bcm_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [bcm_pkg::DEN_W-1:0]    num,
   input  wire logic [bcm_pkg::DEN_W-1:0]    den,
   output logic                              done,
   output logic [bcm_pkg::FRAC_W-1:0]        quotient
);

   logic                           busy_ff;
   logic                           first_ff;
   logic                           done_ff;
   logic [bcm_pkg::ITER_BITS-1:0]  cnt_ff;
   logic [bcm_pkg::DEN_W-1:0]      rem_ff;
   logic [bcm_pkg::DEN_W-1:0]      den_ff;
   logic [bcm_pkg::FRAC_W-1:0]     quo_ff;

   logic [bcm_pkg::DEN_W:0]        trial;
   logic [bcm_pkg::DEN_W:0]        diff;
   logic                           ge;

   // First step compares the numerator itself (the integer bit), then shifts
   assign trial = first_ff ? {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = (trial >= {1'b0, den_ff});

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == bcm_pkg::ITER_BITS'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= bcm_pkg::ITER_BITS'(bcm_pkg::FRAC_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - bcm_pkg::ITER_BITS'(1);
            if (cnt_ff == bcm_pkg::ITER_BITS'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Remainder and quotient
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff   <= num;
         den_ff   <= den;
         quo_ff   <= '0;
         first_ff <= 1'b1;
      end else if (busy_ff) begin
         rem_ff   <= ge ? diff[bcm_pkg::DEN_W-1:0] : trial[bcm_pkg::DEN_W-1:0];
         quo_ff   <= {quo_ff[bcm_pkg::FRAC_W-2:0], ge};
         first_ff <= 1'b0;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

FILE: rtl/bcm_dpath.sv
// bcm_dpath: confusion counters, ratio operand selection, divider, ratio
// and output registers. Uses bcm_pkg and bcm_div.
`default_nettype none
module bcm_dpath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bcm_pkg::req_type      req_data,
   input  wire bcm_pkg::cmd_type      cmd,
   output bcm_pkg::status_type        status,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output bcm_pkg::rsp_type           rsp_data
);

   localparam logic [bcm_pkg::COUNT_BITS-1:0] CNT_MAX = '1;

   logic [bcm_pkg::COUNT_BITS-1:0] tp_ff, tn_ff, fp_ff, fn_ff;
   logic [bcm_pkg::FRAC_W-1:0]     ratio_ff [bcm_pkg::NUM_RATIOS];
   logic [bcm_pkg::NUM_RATIOS-1:0] mask_ff;
   logic                           rsp_valid_ff;
   bcm_pkg::rsp_type               rsp_ff;

   logic p_neg, a_neg, p_nonpos, a_nonpos;
   logic is_tp, is_tn, is_fp, is_fn;
   logic [bcm_pkg::DEN_W-1:0] tp_x, tn_x, fp_x, fn_x;
   logic [bcm_pkg::DEN_W-1:0] num_sel, den_sel;
   logic                      div_done;
   logic [bcm_pkg::FRAC_W-1:0] quotient;
   logic                      out_free;

   // Sign classification; zero counts as both signs, test order decides
   assign p_neg    = req_data.predicted_score[bcm_pkg::INPUT_BITS-1];
   assign a_neg    = req_data.actual_label[bcm_pkg::INPUT_BITS-1];
   assign p_nonpos = p_neg || (req_data.predicted_score == '0);
   assign a_nonpos = a_neg || (req_data.actual_label == '0);
   assign is_tp    = !p_neg && !a_neg;
   assign is_tn    = !is_tp && p_nonpos && a_nonpos;
   assign is_fp    = !is_tp && !is_tn && !p_neg;
   assign is_fn    = !is_tp && !is_tn && p_neg;

   // Saturating counters, cleared when the result is loaded
   always_ff @(posedge clock) begin
      if (reset || cmd.push) begin
         tp_ff <= '0;
         tn_ff <= '0;
         fp_ff <= '0;
         fn_ff <= '0;
      end else if (cmd.count_en) begin
         if (is_tp && tp_ff != CNT_MAX) tp_ff <= tp_ff + bcm_pkg::COUNT_BITS'(1);
         if (is_tn && tn_ff != CNT_MAX) tn_ff <= tn_ff + bcm_pkg::COUNT_BITS'(1);
         if (is_fp && fp_ff != CNT_MAX) fp_ff <= fp_ff + bcm_pkg::COUNT_BITS'(1);
         if (is_fn && fn_ff != CNT_MAX) fn_ff <= fn_ff + bcm_pkg::COUNT_BITS'(1);
      end
   end

   // Ratio operands
   assign tp_x = bcm_pkg::DEN_W'(tp_ff);
   assign tn_x = bcm_pkg::DEN_W'(tn_ff);
   assign fp_x = bcm_pkg::DEN_W'(fp_ff);
   assign fn_x = bcm_pkg::DEN_W'(fn_ff);

   always_comb begin
      case (cmd.sel)
         bcm_pkg::RATIO_ACC: begin
            num_sel = tp_x + tn_x;
            den_sel = tp_x + tn_x + fp_x + fn_x;
         end
         bcm_pkg::RATIO_PREC: begin
            num_sel = tp_x;
            den_sel = tp_x + fp_x;
         end
         bcm_pkg::RATIO_REC: begin
            num_sel = tp_x;
            den_sel = tp_x + fn_x;
         end
         default: begin
            num_sel = {tp_x[bcm_pkg::DEN_W-2:0], 1'b0};
            den_sel = {tp_x[bcm_pkg::DEN_W-2:0], 1'b0} + fn_x + fp_x;
         end
      endcase
   end

   bcm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .num      (num_sel),
      .den      (den_sel),
      .done     (div_done),
      .quotient (quotient)
   );

   // Ratio results; zero denominator gives zero and a mask bit
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         ratio_ff[cmd.sel] <= (den_sel == '0) ? '0 : quotient;
         mask_ff[cmd.sel]  <= (den_sel == '0);
      end
   end

   // Output register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_ff.true_pos_count  <= tp_ff;
         rsp_ff.true_neg_count  <= tn_ff;
         rsp_ff.false_pos_count <= fp_ff;
         rsp_ff.false_neg_count <= fn_ff;
         rsp_ff.accuracy_frac   <= ratio_ff[bcm_pkg::RATIO_ACC];
         rsp_ff.precision_frac  <= ratio_ff[bcm_pkg::RATIO_PREC];
         rsp_ff.recall_frac     <= ratio_ff[bcm_pkg::RATIO_REC];
         rsp_ff.fmeasure_frac   <= ratio_ff[bcm_pkg::RATIO_FMEAS];
         rsp_ff.undefined_mask  <= mask_ff;
      end
   end

   assign status.div_done = div_done;
   assign status.out_free = out_free;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

`ifndef ASSERT_OFF
   // Output register is never overwritten while a result still waits
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> out_free)
      else $error("result loaded over a pending result");

   // Counters are idle while ratios are computed from them
   a_no_count_in_div: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_start || cmd.store) |-> !cmd.count_en)
      else $error("counter update during ratio computation");
`endif

endmodule
`default_nettype wire

FILE: rtl/bcm_ctrl.sv
// bcm_ctrl: sequencer for counting and the four per-set ratio divisions.
// Uses bcm_pkg; drives bcm_dpath through cmd_type and status_type.
`default_nettype none
module bcm_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                last_pair,
   input  wire bcm_pkg::status_type status,
   output bcm_pkg::cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_COUNT,
      ST_START,
      ST_WAIT,
      ST_PUSH
   } state_type;

   state_type                    state_ff;
   logic                         req_ready_ff;
   logic [bcm_pkg::SEL_BITS-1:0] sel_ff;
   logic                         accept;

   assign accept = req_valid && req_ready_ff;

   // State, ratio index and ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COUNT;
         req_ready_ff <= 1'b1;
         sel_ff       <= bcm_pkg::RATIO_ACC;
      end else begin
         case (state_ff)
            ST_COUNT: begin
               if (accept && last_pair) begin
                  state_ff     <= ST_START;
                  req_ready_ff <= 1'b0;
                  sel_ff       <= bcm_pkg::RATIO_ACC;
               end
            end
            ST_START: begin
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (status.div_done) begin
                  if (sel_ff == bcm_pkg::RATIO_FMEAS) begin
                     state_ff <= ST_PUSH;
                  end else begin
                     sel_ff   <= sel_ff + bcm_pkg::SEL_BITS'(1);
                     state_ff <= ST_START;
                  end
               end
            end
            ST_PUSH: begin
               if (status.out_free) begin
                  state_ff     <= ST_COUNT;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= ST_COUNT;
               req_ready_ff <= 1'b1;
            end
         endcase
      end
   end

   // Command decode
   assign cmd.count_en  = accept;
   assign cmd.div_start = (state_ff == ST_START);
   assign cmd.store     = (state_ff == ST_WAIT) && status.div_done;
   assign cmd.push      = (state_ff == ST_PUSH) && status.out_free;
   assign cmd.sel       = sel_ff;
   assign req_ready     = req_ready_ff;

`ifndef ASSERT_OFF
   // Ready only in the counting state
   a_ready_count: assert property (@(posedge clock) disable iff (reset)
      req_ready_ff |-> (state_ff == ST_COUNT))
      else $error("ready outside counting state");

   // A last request always starts the accuracy division next
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && last_pair) |=> (cmd.div_start && sel_ff == bcm_pkg::RATIO_ACC))
      else $error("last request did not start ratio sequence");
`endif

endmodule
`default_nettype wire

FILE: rtl/binary_classifier_metrics.sv
// Binary classifier metrics: confusion counts plus accuracy, precision,
// recall and F-measure per set. A plain pair is counted when accepted; after a
// last pair the four divisions run on one serial divider, then the output
// register is loaded and rsp_valid rises, with req_ready low meanwhile and
// longer while the previous result is held. Throughput: one pair per cycle
// between set ends. Reset (synchronous) clears counters, controller and output.
`default_nettype none
module binary_classifier_metrics (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire bcm_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output bcm_pkg::rsp_type      rsp_data
);

   bcm_pkg::cmd_type    cmd;
   bcm_pkg::status_type status;

   bcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .last_pair (req_data.last_pair),
      .status    (status),
      .cmd       (cmd)
   );

   bcm_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

FILE: bench/tb_binary_classifier_metrics.sv
// Self-checking bench for binary_classifier_metrics: drives (score, label) pairs
// and checks every set result against an in-bench confusion/ratio predictor.
// Depends on bcm_pkg and the binary_classifier_metrics RTL.
`timescale 1ns / 100ps

module tb_binary_classifier_metrics;

   localparam int SETTLE_CYCLES = 120;    // covers the four serial divisions
   localparam int IDLE_PERCENT  = 16;

   typedef enum logic [1:0] {TRUE_POS, TRUE_NEG, FALSE_POS, FALSE_NEG} outcome_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   bcm_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   bcm_pkg::rsp_type rsp_data;

   // Predictor state
   logic [bcm_pkg::COUNT_BITS-1:0] tp_tally, tn_tally, fp_tally, fn_tally;
   bcm_pkg::rsp_type               expected_metrics[$];

   // Run control and bookkeeping
   bit sender_gaps;
   bit receiver_gaps;
   int stall_request;
   int stall_left;
   int mismatch_count;
   int pairs_sent;
   int sets_sent;
   int results_checked;

   binary_classifier_metrics DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Run limit
   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Sign-based class; zero counts as both signs, so test order matters
   function automatic outcome_type classify_pair(
         logic signed [bcm_pkg::INPUT_BITS-1:0] score,
         logic signed [bcm_pkg::INPUT_BITS-1:0] label);
      if (score >= 0 && label >= 0)
         return TRUE_POS;
      else if (score <= 0 && label <= 0)
         return TRUE_NEG;
      else if (score >= 0)
         return FALSE_POS;
      else
         return FALSE_NEG;
   endfunction

   function automatic logic [bcm_pkg::FRAC_W-1:0] fixed_ratio(longint unsigned num,
                                                              longint unsigned den);
      if (den == 0)
         return '0;
      return bcm_pkg::FRAC_W'((num << bcm_pkg::FRAC_BITS) / den);
   endfunction

   function automatic logic [bcm_pkg::COUNT_BITS-1:0] bump(
         logic [bcm_pkg::COUNT_BITS-1:0] tally);
      return (tally == '1) ? tally : tally + bcm_pkg::COUNT_BITS'(1);
   endfunction

   // Count one accepted pair; on the set's last pair queue the metrics
   task automatic tally_pair(bcm_pkg::req_type pair);
      bcm_pkg::rsp_type m;
      longint unsigned  tp, tn, fp, fn;
      case (classify_pair(pair.predicted_score, pair.actual_label))
         TRUE_POS:  tp_tally = bump(tp_tally);
         TRUE_NEG:  tn_tally = bump(tn_tally);
         FALSE_POS: fp_tally = bump(fp_tally);
         default:   fn_tally = bump(fn_tally);
      endcase
      if (pair.last_pair) begin
         tp = 64'(tp_tally);
         tn = 64'(tn_tally);
         fp = 64'(fp_tally);
         fn = 64'(fn_tally);
         m = '0;
         m.true_pos_count  = tp_tally;
         m.true_neg_count  = tn_tally;
         m.false_pos_count = fp_tally;
         m.false_neg_count = fn_tally;
         m.accuracy_frac   = fixed_ratio(tp + tn, tp + tn + fp + fn);
         m.precision_frac  = fixed_ratio(tp, tp + fp);
         m.recall_frac     = fixed_ratio(tp, tp + fn);
         m.fmeasure_frac   = fixed_ratio(2 * tp, 2 * tp + fn + fp);
         m.undefined_mask[bcm_pkg::RATIO_ACC]   = (tp + tn + fp + fn == 0);
         m.undefined_mask[bcm_pkg::RATIO_PREC]  = (tp + fp == 0);
         m.undefined_mask[bcm_pkg::RATIO_REC]   = (tp + fn == 0);
         m.undefined_mask[bcm_pkg::RATIO_FMEAS] = (2 * tp + fn + fp == 0);
         expected_metrics.push_back(m);
         tp_tally = '0;
         tn_tally = '0;
         fp_tally = '0;
         fn_tally = '0;
      end
   endtask

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Result checker and request monitor, both sampled on the rising edge
   always @(posedge clock) begin
      bcm_pkg::rsp_type want;
      if (reset) begin
         tp_tally = '0;
         tn_tally = '0;
         fp_tally = '0;
         fn_tally = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_metrics.size() == 0) begin
               $error("result with no pending set: tp=%0d tn=%0d fp=%0d fn=%0d",
                      rsp_data.true_pos_count, rsp_data.true_neg_count,
                      rsp_data.false_pos_count, rsp_data.false_neg_count);
               mismatch_count++;
            end else begin
               want = expected_metrics.pop_front();
               check_field("true_pos_count", want.true_pos_count, rsp_data.true_pos_count);
               check_field("true_neg_count", want.true_neg_count, rsp_data.true_neg_count);
               check_field("false_pos_count", want.false_pos_count,
                           rsp_data.false_pos_count);
               check_field("false_neg_count", want.false_neg_count,
                           rsp_data.false_neg_count);
               check_field("accuracy_frac", want.accuracy_frac, rsp_data.accuracy_frac);
               check_field("precision_frac", want.precision_frac, rsp_data.precision_frac);
               check_field("recall_frac", want.recall_frac, rsp_data.recall_frac);
               check_field("fmeasure_frac", want.fmeasure_frac, rsp_data.fmeasure_frac);
               check_field("undefined_mask", want.undefined_mask, rsp_data.undefined_mask);
               results_checked++;
            end
         end
         if (req_valid && req_ready)
            tally_pair(req_data);
      end
   end

   // Result receiver: random gaps, plus long hold-offs on request
   initial begin
      rsp_ready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_request > 0) begin
            stall_left = stall_request;
            stall_request = 0;
         end
         if (reset)
            rsp_ready <= 1'b0;
         else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (receiver_gaps)
            rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
         else
            rsp_ready <= 1'b1;
      end
   end

   // Offer one pair at the falling edge and hold it until accepted
   task automatic send_pair(logic signed [bcm_pkg::INPUT_BITS-1:0] score,
                            logic signed [bcm_pkg::INPUT_BITS-1:0] label, bit last);
      while (sender_gaps && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{predicted_score: score, actual_label: label, last_pair: last};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      pairs_sent++;
      if (last)
         sets_sent++;
   endtask

   // Stop offering and wait until every pending set has reported
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_metrics.size() != 0);
   endtask

   // Biased toward zero and the extremes
   function automatic logic signed [bcm_pkg::INPUT_BITS-1:0] pick_value();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return bcm_pkg::INPUT_BITS'(1);
         3:       return {1'b1, {(bcm_pkg::INPUT_BITS-1){1'b0}}};
         4:       return {1'b0, {(bcm_pkg::INPUT_BITS-1){1'b1}}};
         default: return bcm_pkg::INPUT_BITS'($urandom);
      endcase
   endfunction

   task automatic send_random_set(int len);
      for (int i = 0; i < len; i++)
         send_pair(pick_value(), pick_value(), i == len - 1);
   endtask

   function automatic int pick_set_length();
      return ($urandom_range(99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 40);
   endfunction

   // Single-class sets hit the zero precision, recall and F-measure denominators; the mixed set walks zero handling
   task automatic test_directed_cases();
      send_pair(16'sd0, 16'sd0, 1'b1);                  // zero/zero is a true positive
      send_pair(-16'sd32768, -16'sd32768, 1'b1);       // only negatives
      send_pair(16'sd32767, -16'sd1, 1'b1);            // only a false positive
      send_pair(-16'sd1, 16'sd32767, 1'b1);            // only a false negative
      send_pair(16'sd0, -16'sd32768, 1'b0);
      send_pair(-16'sd32768, 16'sd0, 1'b0);
      send_pair(16'sd1, 16'sd0, 1'b0);
      send_pair(16'sd0, 16'sd1, 1'b0);
      send_pair(-16'sd1, -16'sd1, 1'b0);
      send_pair(16'sd32767, 16'sd32767, 1'b0);
      send_pair(16'sd1, -16'sd1, 1'b0);
      send_pair(-16'sd32768, 16'sd1, 1'b0);
      send_pair(16'sd0, 16'sd0, 1'b1);
      wait_for_results();
   endtask

   task automatic test_random_sets(int pair_budget);
      int target;
      target = pairs_sent + pair_budget;
      while (pairs_sent < target)
         send_random_set(pick_set_length());
   endtask

   // Hold results off long enough that the block backs up onto its input
   task automatic test_output_stall();
      stall_request = 400;
      for (int i = 0; i < 40; i++)
         send_random_set($urandom_range(1, 2));
   endtask

   // Sender goes quiet until each set has reported
   task automatic test_sender_pause();
      for (int i = 0; i < 5; i++) begin
         send_random_set(pick_set_length());
         wait_for_results();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      sender_gaps = 1'b1;
      receiver_gaps = 1'b1;
      stall_request = 0;
      mismatch_count = 0;
      pairs_sent = 0;
      sets_sent = 0;
      results_checked = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_cases();
      test_random_sets(350);
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      test_random_sets(200);
      sender_gaps = 1'b1;
      receiver_gaps = 1'b1;
      test_output_stall();
      test_sender_pause();
      test_random_sets(300);

      wait_for_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_metrics.size() != 0) begin
         $error("%0d set results never arrived", expected_metrics.size());
         mismatch_count += expected_metrics.size();
      end
      $display("Sent %0d pairs in %0d sets, %0d results checked.",
               pairs_sent, sets_sent, results_checked);
      $display("Covered zero/extreme signs, empty ratios, gap-free streams and output stalls.");
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
